FILE: rtl/kar_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// kar_pkg
// Shared types and constants of the key axis resolver: field widths, command
// and key state codes, register layout and controller/datapath handshakes.
// ============================================================================
package kar_pkg;

    localparam int KEY_W    = 8;
    localparam int BKEY_W   = 9;
    localparam int SCALE_W  = 16;
    localparam int STATE_W  = 2;
    localparam int MAX_BIND = 4;
    localparam int NUM_REGS = 2 * MAX_BIND;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 3;

    // Value of a key register that matches no key.
    localparam logic [BKEY_W-1:0] KEY_UNUSED = 9'd256;

    // Item command codes.
    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Key state codes; every other code behaves like a held key.
    localparam logic [STATE_W-1:0] ST_PRESS   = 2'd0;
    localparam logic [STATE_W-1:0] ST_RELEASE = 2'd1;
    localparam logic [STATE_W-1:0] ST_HELD    = 2'd2;

    typedef struct packed {
        logic [BKEY_W-1:0]         key;
        logic signed [SCALE_W-1:0] scale;
    } t_bind;

    typedef t_bind [MAX_BIND-1:0] t_bind_arr;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic decode;
        logic compact;
        logic finish;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic release_ev;
        logic compact_done;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/kar_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// kar_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module kar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/kar_cfg.sv
`timescale 1ns / 1ps
// ============================================================================
// kar_cfg
// APB register file holding the key code and scale of each binding.
// ============================================================================
module kar_cfg import kar_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_bind_arr          o_binds
);

    t_bind_arr              r_binds;
    logic [REG_IDX_W-1:0]   w_idx;
    logic                   w_wr;
    logic [MAX_BIND-1:0]    w_sel_bind;

    assign w_idx      = paddr[PADDR_W-1:2];
    assign w_wr       = psel && penable && pwrite;
    assign w_sel_bind = MAX_BIND'(1) << w_idx[REG_IDX_W-1:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_BIND; i++) begin
                r_binds[i].key   <= KEY_UNUSED;
                r_binds[i].scale <= '0;
            end
        end else if (w_wr) begin
            for (int i = 0; i < MAX_BIND; i++) begin
                if (w_sel_bind[i]) begin
                    if (!w_idx[0]) begin
                        r_binds[i].key <= pwdata[BKEY_W-1:0];
                    end else begin
                        r_binds[i].scale <= pwdata[SCALE_W-1:0];
                    end
                end
            end
        end
    end

    always_comb begin
        if (!w_idx[0]) begin
            prdata = PDATA_W'(r_binds[w_idx[REG_IDX_W-1:1]].key);
        end else begin
            prdata = PDATA_W'(r_binds[w_idx[REG_IDX_W-1:1]].scale);
        end
    end

    assign pready  = 1'b1;
    assign o_binds = r_binds;

endmodule

FILE: rtl/kar_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// kar_ctrl
// Sequencer of the resolver: decode, queue compaction, finish, result hand-off.
// ============================================================================
module kar_ctrl import kar_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_COMPACT = 3'd2;
    localparam logic [2:0] S_FINISH  = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state = i_stat.release_ev ? S_COMPACT : S_DONE;
            end
            S_COMPACT: begin
                o_cmd.compact = 1'b1;
                if (i_stat.compact_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: rtl/kar_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// kar_dp
// Datapath: item registers, binding lookup, pressed-key queue with its
// compaction pass, axis register and the output register.
// ============================================================================
module kar_dp import kar_pkg::*; #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int NUM_BINDINGS = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat,
    input  t_bind_arr                 i_binds,
    input  logic                      i_item_cmd,
    input  logic [KEY_W-1:0]          i_item_key,
    input  logic [STATE_W-1:0]        i_item_state,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic signed [SCALE_W-1:0] o_out_axis,
    output logic                      o_out_dropped
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    function automatic logic [SCALE_W:0] f_lookup(input logic [KEY_W-1:0] k,
                                                   input t_bind_arr b);
        logic [SCALE_W:0] res;
        res = '0;
        for (int i = NUM_BINDINGS - 1; i >= 0; i--) begin
            if (b[i].key == {1'b0, k}) begin
                res = {1'b1, b[i].scale};
            end
        end
        return res;
    endfunction

    logic                      r_cmd;
    logic [KEY_W-1:0]          r_key;
    logic [STATE_W-1:0]        r_kstate;
    logic [CNT_W-1:0]          r_count,  n_count;
    logic signed [SCALE_W-1:0] r_axis,   n_axis;
    logic                      r_dropped, n_dropped;
    logic [CNT_W-1:0]          r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]          r_wr_idx, n_wr_idx;
    logic                      r_pend,   n_pend;
    logic [KEY_W-1:0]          r_first,  n_first;
    logic                      r_out_valid;
    logic signed [SCALE_W-1:0] r_out_axis;
    logic                      r_out_dropped;

    logic                      w_we;
    logic [IDX_W-1:0]          w_waddr;
    logic [KEY_W-1:0]          w_wdata;
    logic [IDX_W-1:0]          w_raddr;
    logic [KEY_W-1:0]          w_rdata;
    logic [SCALE_W:0]          w_item_hit;
    logic [SCALE_W:0]          w_first_hit;
    logic                      w_event;

    kar_ram #(
        .WIDTH (KEY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_item_hit  = f_lookup(r_key, i_binds);
    assign w_first_hit = f_lookup(r_first, i_binds);
    assign w_event     = (r_cmd == CMD_EVENT) && w_item_hit[SCALE_W] &&
                         ((r_kstate == ST_PRESS) || (r_kstate == ST_RELEASE));

    always_comb begin
        n_count   = r_count;
        n_axis    = r_axis;
        n_dropped = r_dropped;
        n_rd_idx  = r_rd_idx;
        n_wr_idx  = r_wr_idx;
        n_pend    = r_pend;
        n_first   = r_first;
        w_we      = 1'b0;
        w_waddr   = r_count[IDX_W-1:0];
        w_wdata   = r_key;
        w_raddr   = '0;

        if (i_cmd.decode) begin
            n_dropped = 1'b0;
            if (r_cmd == CMD_CLEAR) begin
                n_count = '0;
                n_axis  = '0;
            end else if (w_event && (r_kstate == ST_PRESS)) begin
                n_axis = w_item_hit[SCALE_W-1:0];
                if (r_count < CNT_FULL) begin
                    w_we    = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end else begin
                    n_dropped = 1'b1;
                end
            end else if (w_event) begin
                // Release: start the walk by reading the oldest entry.
                n_pend   = (r_count != '0);
                n_rd_idx = CNT_W'(1);
                n_wr_idx = '0;
            end
        end

        if (i_cmd.compact) begin
            if (r_pend) begin
                if (w_rdata != r_key) begin
                    w_we     = 1'b1;
                    w_waddr  = r_wr_idx[IDX_W-1:0];
                    w_wdata  = w_rdata;
                    n_wr_idx = r_wr_idx + CNT_W'(1);
                    if (r_wr_idx == '0) begin
                        n_first = w_rdata;
                    end
                end
            end
            w_raddr = r_rd_idx[IDX_W-1:0];
            n_pend  = r_pend && (r_rd_idx < r_count);
            if (n_pend) begin
                n_rd_idx = r_rd_idx + CNT_W'(1);
            end
        end

        if (i_cmd.finish) begin
            n_count = r_wr_idx;
            if ((r_wr_idx != '0) && w_first_hit[SCALE_W]) begin
                n_axis = w_first_hit[SCALE_W-1:0];
            end else begin
                n_axis = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_axis      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_axis  <= n_axis;
            r_pend  <= n_pend;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd    <= i_item_cmd;
            r_key    <= i_item_key;
            r_kstate <= i_item_state;
        end
        if (i_cmd.load_out) begin
            r_out_axis    <= r_axis;
            r_out_dropped <= r_dropped;
        end
        r_dropped <= n_dropped;
        r_rd_idx  <= n_rd_idx;
        r_wr_idx  <= n_wr_idx;
        r_first   <= n_first;
    end

    assign o_stat.release_ev   = w_event && (r_kstate == ST_RELEASE);
    assign o_stat.compact_done = !r_pend;
    assign o_stat.out_free     = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_out_axis    = r_out_axis;
    assign o_out_dropped = r_out_dropped;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond queue depth");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.compact && r_pend) |-> (r_wr_idx < r_rd_idx))
        else $error("compaction write index caught up with read index");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decode && (r_cmd == CMD_CLEAR)) |=> (r_count == '0 && r_axis == '0))
        else $error("clear command left queue or axis set");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("result load did not raise output valid");

endmodule

FILE: rtl/key_axis_resolver.sv
`timescale 1ns / 1ps
// ============================================================================
// key_axis_resolver
// Resolves key press and release events into one signed Q1.14 axis value.
// ============================================================================
// Each accepted item yields exactly one result: the axis value after the item
// and a flag that is set when a press found the queue of pressed keys full.
// Up to four bindings (key code plus scale) are written over the APB port at
// byte addresses 0x00 through 0x1C, key then scale for each binding, and
// should only be changed while no item is in flight. A press, a held key, an
// unbound key or a clear command goes from decode to the done state, where
// its result is loaded once the output register is free, and the next item
// can then be accepted. A release walks the whole queue once through the
// single read port of the queue RAM, one entry per cycle, and then a finish
// step. The result sits in an output register, so the block accepts the next
// item while that result is still stalled downstream. The queue RAM needs no
// clearing after reset, because only entries below the fill count are used.
// ============================================================================
module key_axis_resolver import kar_pkg::*; #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int NUM_BINDINGS = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Input item channel.
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_cmd,
    input  logic [KEY_W-1:0]          i_key_code,
    input  logic [STATE_W-1:0]        i_key_state,
    // Result item channel.
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [SCALE_W-1:0] o_axis_value,
    output logic                      o_queue_dropped,
    // Configuration port.
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    t_bind_arr w_binds;
    t_dp_cmd   w_cmd;
    t_dp_stat  w_stat;
    logic      w_busy;

    // Binding registers.
    kar_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_binds (w_binds)
    );

    // The controller takes an item whenever it is back in its idle state.
    kar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    // Queue, lookup and axis state, plus the result register.
    kar_dp #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .NUM_BINDINGS (NUM_BINDINGS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_binds       (w_binds),
        .i_item_cmd    (i_cmd),
        .i_item_key    (i_key_code),
        .i_item_state  (i_key_state),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_out_axis    (o_axis_value),
        .o_out_dropped (o_queue_dropped)
    );

    assign o_stall = w_busy;

endmodule

FILE: tb/key_axis_resolver_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// key_axis_resolver_tb
// Self-checking bench for the key axis resolver. Bindings are written over
// the APB port between phases. Key events go in with bursty pacing while the
// result side stalls on its own pattern. A tracker mirrors the pressed-key
// queue and the axis value, and checks every result field by field.
// ============================================================================

module key_axis_resolver_tb;
    import kar_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int NUM_BINDINGS   = 4;
    localparam int REGS_PER_BIND  = 2;
    localparam int REG_KEY_OFS    = 0;
    localparam int REG_SCALE_OFS  = 1;
    localparam int PHASE_ITEMS    = 250;
    localparam int RANDOM_PHASES  = 7;
    localparam int UNBOUND_PHASE  = 2;
    localparam int STEADY_PHASE   = 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_FIRST  = 400;
    localparam int HOLD_AT_SECOND = 1400;
    localparam int DRAIN_CYCLES   = 40;
    // A long receiver hold plus the slowest release walk, with ample margin.
    localparam int WATCHDOG_LIMIT = 4000;

    // Mirrors the resolver state and keeps the results still owed by the block.
    class t_axis_tracker;

        typedef struct {
            logic signed [kar_pkg::SCALE_W-1:0] axis;
            logic                               dropped;
        } t_axis_result;

        logic [kar_pkg::BKEY_W-1:0]         bind_key[kar_pkg::MAX_BIND];
        logic signed [kar_pkg::SCALE_W-1:0] bind_scale[kar_pkg::MAX_BIND];
        logic [kar_pkg::KEY_W-1:0]          pressed_keys[$];
        logic signed [kar_pkg::SCALE_W-1:0] axis;
        t_axis_result                       expected_axis[$];
        int                                 mismatches;
        int                                 results_checked;

        function new();
            foreach (bind_key[i]) begin
                bind_key[i]   = kar_pkg::KEY_UNUSED;
                bind_scale[i] = '0;
            end
            axis            = '0;
            mismatches      = 0;
            results_checked = 0;
        endfunction

        function void set_binding(int b, logic [kar_pkg::BKEY_W-1:0] key,
                                  logic signed [kar_pkg::SCALE_W-1:0] scale);
            bind_key[b]   = key;
            bind_scale[b] = scale;
        endfunction

        // Lowest-numbered binding wins when several carry the same key.
        function int binding_of(logic [kar_pkg::KEY_W-1:0] key);
            for (int b = 0; b < NUM_BINDINGS; b++) begin
                if (bind_key[b] == {1'b0, key}) return b;
            end
            return -1;
        endfunction

        function logic signed [kar_pkg::SCALE_W-1:0] scale_of(logic [kar_pkg::KEY_W-1:0] key);
            int b;
            b = binding_of(key);
            return (b < 0) ? '0 : bind_scale[b];
        endfunction

        function int outstanding();
            return expected_axis.size();
        endfunction

        function void note_event(logic cmd, logic [kar_pkg::KEY_W-1:0] key,
                                 logic [kar_pkg::STATE_W-1:0] st);
            t_axis_result              res;
            logic [kar_pkg::KEY_W-1:0] kept[$];
            res.dropped = 1'b0;
            if (cmd == kar_pkg::CMD_CLEAR) begin
                pressed_keys.delete();
                axis = '0;
            end else if ((st == kar_pkg::ST_PRESS || st == kar_pkg::ST_RELEASE)
                         && binding_of(key) >= 0) begin
                if (st == kar_pkg::ST_PRESS) begin
                    // A press always moves the axis, even when the key is dropped.
                    axis = scale_of(key);
                    if (pressed_keys.size() < QUEUE_DEPTH)
                        pressed_keys.insert(pressed_keys.size(), key);
                    else res.dropped = 1'b1;
                end else begin
                    foreach (pressed_keys[i]) begin
                        if (pressed_keys[i] != key) kept.insert(kept.size(), pressed_keys[i]);
                    end
                    pressed_keys = kept;
                    axis = (pressed_keys.size() > 0) ? scale_of(pressed_keys[0]) : '0;
                end
            end
            res.axis = axis;
            expected_axis.insert(expected_axis.size(), res);
        endfunction

        task report(string msg);
            mismatches++;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_axis(logic signed [kar_pkg::SCALE_W-1:0] got_axis, logic got_dropped);
            t_axis_result res;
            if (expected_axis.size() == 0) begin
                report($sformatf("unexpected result axis=%0d dropped=%b", got_axis, got_dropped));
            end else begin
                res = expected_axis.pop_front();
                if (got_axis !== res.axis)
                    report($sformatf("result %0d axis_value got %0d want %0d",
                                     results_checked, got_axis, res.axis));
                if (got_dropped !== res.dropped)
                    report($sformatf("result %0d queue_dropped got %b want %b",
                                     results_checked, got_dropped, res.dropped));
            end
            results_checked++;
        endtask

    endclass

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_valid         = 1'b0;
    logic                      i_cmd           = CMD_EVENT;
    logic [KEY_W-1:0]          i_key_code      = '0;
    logic [STATE_W-1:0]        i_key_state     = ST_HELD;
    logic                      i_stall         = 1'b0;
    logic                      psel            = 1'b0;
    logic                      penable         = 1'b0;
    logic                      pwrite          = 1'b0;
    logic [PADDR_W-1:0]        paddr           = '0;
    logic [PDATA_W-1:0]        pwdata          = '0;
    logic                      o_stall;
    logic                      o_valid;
    logic signed [SCALE_W-1:0] o_axis_value;
    logic                      o_queue_dropped;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    // Current key registers, used to aim random events at bound keys.
    logic [BKEY_W-1:0] cfg_key[MAX_BIND] = '{default: KEY_UNUSED};
    int                burst_left  = 0;
    bit                steady      = 1'b0;
    int                results_seen = 0;
    int                idle_run    = 0;

    t_axis_tracker tracker = new();

    key_axis_resolver #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_BINDINGS(NUM_BINDINGS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_key_code     (i_key_code),
        .i_key_state    (i_key_state),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_axis_value   (o_axis_value),
        .o_queue_dropped(o_queue_dropped),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input int idx, input logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= PADDR_W'(4 * idx);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_binding(input int b, input logic [BKEY_W-1:0] key,
                                 input logic signed [SCALE_W-1:0] scale);
        write_reg(REGS_PER_BIND * b + REG_KEY_OFS, PDATA_W'(key));
        write_reg(REGS_PER_BIND * b + REG_SCALE_OFS, {16'h0000, scale});
        cfg_key[b] = key;
        tracker.set_binding(b, key, scale);
    endtask

    // Drops valid and lets every owed result drain before a register write.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_event(input logic cmd, input logic [KEY_W-1:0] key,
                              input logic [STATE_W-1:0] st);
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_key_code  <= key;
        i_key_state <= st;
        do @(posedge i_clk); while (o_stall);
        tracker.note_event(cmd, key, st);
    endtask

    // Sender pacing: bursts of random length, random gaps between them.
    task automatic pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!steady && $urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(1, 12)) begin
                    @(negedge i_clk);
                    i_valid <= 1'b0;
                end
            end
        end
        burst_left--;
    endtask

    // Mostly keys that some binding carries, so presses and releases take effect.
    function automatic logic [KEY_W-1:0] pick_key();
        int b;
        b = $urandom_range(0, MAX_BIND - 1);
        if (cfg_key[b] < KEY_UNUSED && $urandom_range(0, 99) < 85) return cfg_key[b][KEY_W-1:0];
        return KEY_W'($urandom_range(0, 255));
    endfunction

    task automatic randomize_bindings();
        logic [BKEY_W-1:0]         key;
        logic signed [SCALE_W-1:0] scale;
        int                        r;
        for (int b = 0; b < MAX_BIND; b++) begin
            r = $urandom_range(0, 99);
            if (r < 15 && b > 0) key = cfg_key[$urandom_range(0, b - 1)];
            else if (r < 30) key = BKEY_W'($urandom_range(256, 511));
            else key = BKEY_W'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            if (r < 10) scale = 16'sh8000;
            else if (r < 20) scale = 16'sh7FFF;
            else if (r < 25) scale = '0;
            else scale = SCALE_W'($urandom);
            write_binding(b, key, scale);
        end
    endtask

    task automatic run_phase(input int n_items, input int press_pct, input bit no_gaps);
        int                 r;
        logic               cmd;
        logic [STATE_W-1:0] st;
        steady = no_gaps;
        for (int i = 0; i < n_items; i++) begin
            r   = $urandom_range(0, 99);
            cmd = ($urandom_range(0, 99) < 3) ? CMD_CLEAR : CMD_EVENT;
            // Held and the unused fourth state both leave the axis alone.
            if (r < 8) st = ST_HELD | STATE_W'($urandom_range(0, 1));
            else if (r < 8 + press_pct) st = ST_PRESS;
            else st = ST_RELEASE;
            pace();
            send_event(cmd, pick_key(), st);
        end
        steady = 1'b0;
    endtask

    // Result side: stalls on a pattern whose mode is redrawn at random over the run, and
    // twice holds off for a long stretch so the block backs up into its input.
    initial begin : result_sink
        int cyc;
        int mode;
        int hold_left;
        int holds_done;
        cyc        = 0;
        mode       = 0;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 200 == 0) mode = $urandom_range(0, 3);
            if (hold_left == 0 && holds_done < 2 &&
                results_seen >= ((holds_done == 0) ? HOLD_AT_FIRST : HOLD_AT_SECOND)) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ((cyc % 7) < 3);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.check_axis(o_axis_value, o_queue_dropped);
            results_seen++;
        end
    end

    // Ends the run when neither channel has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_run = 0;
        else idle_run++;
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // With reset bindings nothing is bound, so a press changes nothing.
        send_event(CMD_EVENT, 8'd0, ST_PRESS);
        settle();

        // Extreme keys and scales; bindings 2 and 3 share a key.
        write_binding(0, 9'd0, 16'sh8000);
        write_binding(1, 9'd255, 16'sh7FFF);
        write_binding(2, 9'h055, 16'sh1234);
        write_binding(3, 9'h055, -16'sh0CDE);
        send_event(CMD_EVENT, 8'd0, ST_PRESS);
        send_event(CMD_EVENT, 8'd255, ST_PRESS);
        send_event(CMD_EVENT, 8'd255, ST_HELD);
        send_event(CMD_EVENT, 8'd0, ST_HELD | ST_RELEASE);
        send_event(CMD_EVENT, 8'h77, ST_PRESS);
        send_event(CMD_EVENT, 8'h55, ST_PRESS);
        send_event(CMD_EVENT, 8'h42, ST_RELEASE);
        send_event(CMD_EVENT, 8'd255, ST_RELEASE);
        // Releasing a bound key that is no longer queued recomputes the axis.
        send_event(CMD_EVENT, 8'd255, ST_RELEASE);
        send_event(CMD_EVENT, 8'd0, ST_RELEASE);
        send_event(CMD_CLEAR, 8'hA5, ST_PRESS);
        // Fill the queue and press once more into the full queue.
        for (int k = 0; k <= QUEUE_DEPTH; k++) begin
            send_event(CMD_EVENT, k[0] ? 8'd255 : 8'd0, ST_PRESS);
        end
        settle();

        // Key 0 stays queued but loses its binding; a key register of 511 never matches.
        write_binding(0, 9'h1FF, 16'sh4000);
        write_binding(1, 9'd255, 16'sh0000);
        write_binding(2, KEY_UNUSED, -16'sh0001);
        write_binding(3, 9'h0AA, 16'sh0001);
        send_event(CMD_EVENT, 8'd255, ST_RELEASE);
        run_phase(PHASE_ITEMS, 50, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            if (p == UNBOUND_PHASE) begin
                for (int b = 0; b < MAX_BIND; b++) begin
                    write_binding(b, KEY_UNUSED, SCALE_W'($urandom));
                end
                run_phase(50, 50, 1'b0);
            end else begin
                randomize_bindings();
                run_phase(PHASE_ITEMS, $urandom_range(35, 70), p == STEADY_PHASE);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/kar_pkg.sv
rtl/kar_ram.sv
rtl/kar_cfg.sv
rtl/kar_ctrl.sv
rtl/kar_dp.sv
rtl/key_axis_resolver.sv
tb/key_axis_resolver_tb.sv
